// ===== rtl/lphs_pkg.sv =====
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared types and constants for the linear probing hash set.
// ----------------------------------------------------------------------------
`default_nettype none

package lphs_pkg;

	localparam int DEF_TABLE_SLOTS = 1024;

	localparam int KEY_W        = 32;
	localparam int HASH_W       = 32;
	localparam int STATUS_W     = 3;
	localparam int SLOT_OUT_W   = 10;
	localparam int S_TDATA_W    = KEY_W + HASH_W;
	localparam int M_TDATA_W    = 16;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_NEW     = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_PRESENT = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_FOUND   = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_ABSENT  = 3'd4;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE,
		ST_RESP
	} state_t;

	// outcome of comparing one slot
	typedef struct packed {
		logic match;
		logic empty;
		logic last;
	} probe_res_t;

endpackage

`default_nettype wire

// ===== rtl/lphs_key_ram.sv =====
// ----------------------------------------------------------------------------
// lphs_key_ram
// Key store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lphs_key_ram #(
	parameter int TABLE_SLOTS = lphs_pkg::DEF_TABLE_SLOTS,
	localparam int SLOT_W = $clog2(TABLE_SLOTS)
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [SLOT_W-1:0]          waddr,
	input  wire logic [lphs_pkg::KEY_W-1:0] wdata,
	input  wire logic [SLOT_W-1:0]          raddr,
	output      logic [lphs_pkg::KEY_W-1:0] rdata
);

	logic [lphs_pkg::KEY_W-1:0] mem [TABLE_SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/lphs_probe_unit.sv =====
// ----------------------------------------------------------------------------
// lphs_probe_unit
// Shared slot compare and next-slot step, used once per probed slot.
// ----------------------------------------------------------------------------
`default_nettype none

module lphs_probe_unit #(
	parameter int TABLE_SLOTS = lphs_pkg::DEF_TABLE_SLOTS,
	localparam int SLOT_W = $clog2(TABLE_SLOTS)
) (
	input  wire logic [lphs_pkg::KEY_W-1:0] slot_key,
	input  wire logic [lphs_pkg::KEY_W-1:0] key,
	input  wire logic [SLOT_W-1:0]          addr,
	input  wire logic [SLOT_W-1:0]          count,
	output      lphs_pkg::probe_res_t       res,
	output      logic [SLOT_W-1:0]          next_addr
);

	always_comb begin
		res.match = (slot_key == key);
		res.empty = (slot_key == '0);
		// every slot has been visited once this one is done
		res.last  = (count == {SLOT_W{1'b1}});
		// wraps at the table size by width
		next_addr = addr + {{(SLOT_W-1){1'b0}}, 1'b1};
	end

endmodule

`default_nettype wire

// ===== rtl/linear_probe_hash_set.sv =====
// An accepted item goes from ST_IDLE to ST_PROBE, which reads one key store
// slot per cycle until a match, an empty slot or the last slot, then to ST_RESP,
// which loads the output register; a zero key skips ST_PROBE. Flow: one item
// at a time, as s_tready is high only in ST_IDLE, and ST_RESP waits while
// m_tready holds a result. Reset: arst_n clears control; the key store is then
// zeroed one slot a cycle, all TABLE_SLOTS (1024 by default), with s_tready low.
// ----------------------------------------------------------------------------
// linear_probe_hash_set
// Open addressing set of nonzero keys with linear probing and a 3/4 fill cap.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_set #(
	parameter int TABLE_SLOTS = lphs_pkg::DEF_TABLE_SLOTS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output      logic                           s_tready,
	input  wire logic [lphs_pkg::S_TDATA_W-1:0] s_tdata,  // key_id, key_hash
	input  wire logic [0:0]                     s_tuser,  // cmd
	output      logic                           m_tvalid,
	input  wire logic                           m_tready,
	output      logic [lphs_pkg::M_TDATA_W-1:0] m_tdata,  // slot, zero pad
	output      logic [lphs_pkg::STATUS_W-1:0]  m_tuser   // status
);

	localparam int SLOT_W     = $clog2(TABLE_SLOTS);
	localparam int LOAD_LIMIT = TABLE_SLOTS * 3 / 4;

	lphs_pkg::state_t state_q, state_d;

	logic [SLOT_W-1:0] clr_q;
	logic [SLOT_W:0]   fill_q;
	logic              fill_inc;

	logic [SLOT_W-1:0]          addr_q, addr_d;
	logic [SLOT_W-1:0]          count_q, count_d;
	logic [lphs_pkg::KEY_W-1:0] key_q;
	logic                       cmd_q;

	logic [lphs_pkg::STATUS_W-1:0]   res_status_q, res_status_d;
	logic [lphs_pkg::SLOT_OUT_W-1:0] res_slot_q, res_slot_d;
	logic                            res_load;

	logic                            m_valid_q;
	logic [lphs_pkg::STATUS_W-1:0]   m_status_q;
	logic [lphs_pkg::SLOT_OUT_W-1:0] m_slot_q;
	logic                            out_load;

	logic                       we;
	logic [SLOT_W-1:0]          waddr;
	logic [lphs_pkg::KEY_W-1:0] wdata;
	logic [SLOT_W-1:0]          raddr;
	logic [lphs_pkg::KEY_W-1:0] rdata;

	lphs_pkg::probe_res_t pres;
	logic [SLOT_W-1:0]    next_addr;

	logic                       in_xfer;
	logic [lphs_pkg::KEY_W-1:0] in_key;
	logic                       in_cmd;
	logic [SLOT_W-1:0]          in_home;

	assign in_key  = s_tdata[lphs_pkg::KEY_W-1:0];
	assign in_home = s_tdata[lphs_pkg::KEY_W +: SLOT_W];
	assign in_cmd  = s_tuser[0];
	assign in_xfer = s_tvalid && s_tready;

	lphs_key_ram #(.TABLE_SLOTS(TABLE_SLOTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	lphs_probe_unit #(.TABLE_SLOTS(TABLE_SLOTS)) u_probe (
		.slot_key  (rdata),
		.key       (key_q),
		.addr      (addr_q),
		.count     (count_q),
		.res       (pres),
		.next_addr (next_addr)
	);

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		addr_d       = addr_q;
		count_d      = count_q;
		raddr        = addr_q;
		we           = 1'b0;
		waddr        = addr_q;
		wdata        = key_q;
		fill_inc     = 1'b0;
		res_load     = 1'b0;
		res_status_d = res_status_q;
		res_slot_d   = res_slot_q;
		out_load     = 1'b0;
		case (state_q)
			lphs_pkg::ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
				if (clr_q == {SLOT_W{1'b1}}) begin
					state_d = lphs_pkg::ST_IDLE;
				end
			end
			lphs_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				raddr    = in_home;
				addr_d   = in_home;
				count_d  = '0;
				if (s_tvalid) begin
					if (in_key == '0) begin
						res_load     = 1'b1;
						res_status_d = (in_cmd == lphs_pkg::CMD_INSERT) ?
							lphs_pkg::STAT_FULL : lphs_pkg::STAT_ABSENT;
						res_slot_d   = '0;
						state_d      = lphs_pkg::ST_RESP;
					end else begin
						state_d = lphs_pkg::ST_PROBE;
					end
				end
			end
			lphs_pkg::ST_PROBE: begin
				res_slot_d = lphs_pkg::SLOT_OUT_W'(addr_q);
				if (pres.match) begin
					res_load     = 1'b1;
					res_status_d = (cmd_q == lphs_pkg::CMD_INSERT) ?
						lphs_pkg::STAT_PRESENT : lphs_pkg::STAT_FOUND;
					state_d      = lphs_pkg::ST_RESP;
				end else if (pres.empty || pres.last) begin
					res_load = 1'b1;
					state_d  = lphs_pkg::ST_RESP;
					if (cmd_q == lphs_pkg::CMD_LOOKUP) begin
						res_status_d = lphs_pkg::STAT_ABSENT;
						res_slot_d   = '0;
					end else if (!pres.empty ||
					             fill_q >= (SLOT_W+1)'(LOAD_LIMIT)) begin
						res_status_d = lphs_pkg::STAT_FULL;
						res_slot_d   = '0;
					end else begin
						we           = 1'b1;
						fill_inc     = 1'b1;
						res_status_d = lphs_pkg::STAT_NEW;
					end
				end else begin
					raddr   = next_addr;
					addr_d  = next_addr;
					count_d = count_q + {{(SLOT_W-1){1'b0}}, 1'b1};
				end
			end
			lphs_pkg::ST_RESP: begin
				if (!m_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = lphs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lphs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lphs_pkg::ST_CLEAR;
			clr_q     <= '0;
			fill_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lphs_pkg::ST_CLEAR) begin
				clr_q <= clr_q + {{(SLOT_W-1){1'b0}}, 1'b1};
			end
			if (fill_inc) begin
				fill_q <= fill_q + {{SLOT_W{1'b0}}, 1'b1};
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_q  <= addr_d;
		count_q <= count_d;
		if (in_xfer) begin
			key_q <= in_key;
			cmd_q <= in_cmd;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_slot_q   <= res_slot_d;
		end
		if (out_load) begin
			m_status_q <= res_status_q;
			m_slot_q   <= res_slot_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {{(lphs_pkg::M_TDATA_W-lphs_pkg::SLOT_OUT_W){1'b0}}, m_slot_q};

	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (SLOT_W+1)'(LOAD_LIMIT))
		else $error("fill count above load limit");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |->
		(fill_q == $past(fill_q) + {{SLOT_W{1'b0}}, 1'b1} &&
		 state_q == lphs_pkg::ST_RESP && res_status_q == lphs_pkg::STAT_NEW))
		else $error("fill count moved without a new insert");

	a_probe_write: assert property (@(posedge clk) disable iff (!arst_n)
		(we && state_q == lphs_pkg::ST_PROBE) |->
		(cmd_q == lphs_pkg::CMD_INSERT && key_q != '0 && pres.empty))
		else $error("key store written outside an insert into an empty slot");

	a_out_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == lphs_pkg::ST_RESP))
		else $error("result raised outside the response state");

endmodule

`default_nettype wire

// ===== dv/tb_linear_probe_hash_set.sv =====
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_set
// Drives insert and lookup commands into the hash set under random stream
// gaps and back-pressure. A behavioral copy of the key table predicts status
// and slot for every transfer. The random part fills the table to its load
// cap with clustered and wrapping home slots. It then keeps hitting the cap
// with refused inserts, repeat inserts and lookups.
// ----------------------------------------------------------------------------

module tb_linear_probe_hash_set;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS       = lphs_pkg::DEF_TABLE_SLOTS;
	localparam int LOAD_LIMIT  = SLOTS * 3 / 4;
	localparam int CYCLE_LIMIT = 4_000_000;

	typedef struct packed {
		logic                            cmd;
		logic [lphs_pkg::KEY_W-1:0]      key;
		logic [lphs_pkg::HASH_W-1:0]     hash;
		logic                            fixed;
		logic [lphs_pkg::STATUS_W-1:0]   st;
		logic [lphs_pkg::SLOT_OUT_W-1:0] sl;
	} op_row_t;

	typedef struct {
		logic [lphs_pkg::STATUS_W-1:0]   st;
		logic [lphs_pkg::SLOT_OUT_W-1:0] sl;
	} outcome_t;

	typedef struct {
		logic [lphs_pkg::KEY_W-1:0]  key;
		logic [lphs_pkg::HASH_W-1:0] hash;
	} stored_key_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [lphs_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic [0:0]                     s_tuser = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [lphs_pkg::M_TDATA_W-1:0] m_tdata;
	logic [lphs_pkg::STATUS_W-1:0]  m_tuser;

	bit [lphs_pkg::KEY_W-1:0] store_keys [SLOTS];
	int unsigned              store_fill;
	outcome_t                 outcome_q [$];
	stored_key_t              stored_q [$];
	bit                       in_set [bit [lphs_pkg::KEY_W-1:0]];
	bit                       calm;
	int                       mismatches;
	int unsigned              cycles;

	// zero key: insert refused, lookup absent; extremes of key and hash;
	// wrap past the last slot; repeat insert; same key under a second hash
	op_row_t directed_ops [] = '{
		'{lphs_pkg::CMD_LOOKUP, 32'h0000_0005, 32'h0000_0000, 1'b1,
			lphs_pkg::STAT_ABSENT, 10'd0},
		'{lphs_pkg::CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1,
			lphs_pkg::STAT_FULL, 10'd0},
		'{lphs_pkg::CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
			lphs_pkg::STAT_ABSENT, 10'd0},
		'{lphs_pkg::CMD_INSERT, 32'h0000_0001, 32'h0000_0000, 1'b1,
			lphs_pkg::STAT_NEW, 10'd0},
		'{lphs_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			lphs_pkg::STAT_NEW, 10'd1023},
		'{lphs_pkg::CMD_INSERT, 32'h0000_DEAD, 32'h0000_03FF, 1'b0,
			lphs_pkg::STAT_NEW, 10'd0},
		'{lphs_pkg::CMD_LOOKUP, 32'h0000_DEAD, 32'hFFFF_FFFF, 1'b0,
			lphs_pkg::STAT_NEW, 10'd0},
		'{lphs_pkg::CMD_INSERT, 32'h0000_0001, 32'h0000_0000, 1'b1,
			lphs_pkg::STAT_PRESENT, 10'd0},
		'{lphs_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_03FF, 1'b1,
			lphs_pkg::STAT_FOUND, 10'd1023},
		'{lphs_pkg::CMD_LOOKUP, 32'h0000_0002, 32'h0000_0000, 1'b0,
			lphs_pkg::STAT_NEW, 10'd0},
		'{lphs_pkg::CMD_INSERT, 32'h8000_0000, 32'hAAAA_AAAA, 1'b0,
			lphs_pkg::STAT_NEW, 10'd0},
		'{lphs_pkg::CMD_INSERT, 32'h5555_5555, 32'h5555_5555, 1'b0,
			lphs_pkg::STAT_NEW, 10'd0},
		'{lphs_pkg::CMD_LOOKUP, 32'h8000_0000, 32'hAAAA_AAAA, 1'b0,
			lphs_pkg::STAT_NEW, 10'd0},
		'{lphs_pkg::CMD_LOOKUP, 32'h5555_5555, 32'h0000_0155, 1'b0,
			lphs_pkg::STAT_NEW, 10'd0},
		'{lphs_pkg::CMD_INSERT, 32'h0000_0001, 32'h0000_0005, 1'b0,
			lphs_pkg::STAT_NEW, 10'd0},
		'{lphs_pkg::CMD_LOOKUP, 32'h0000_0001, 32'h0000_0400, 1'b1,
			lphs_pkg::STAT_FOUND, 10'd0},
		'{lphs_pkg::CMD_INSERT, 32'h0000_0000, 32'h1234_5678, 1'b1,
			lphs_pkg::STAT_FULL, 10'd0},
		'{lphs_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0,
			lphs_pkg::STAT_NEW, 10'd0},
		'{lphs_pkg::CMD_INSERT, 32'h0000_DEAD, 32'h0000_0000, 1'b0,
			lphs_pkg::STAT_NEW, 10'd0}
	};

	linear_probe_hash_set #(
		.TABLE_SLOTS(SLOTS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // key_id, key_hash
		.s_tuser  (s_tuser),   // cmd
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // slot, zero pad
		.m_tuser  (m_tuser)    // status
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("** linear_probe_hash_set: FAILED **");
			$finish;
		end
	end

	// walks the table from the home slot and applies the command to it
	function automatic void set_outcome(input logic cmd,
		input logic [lphs_pkg::KEY_W-1:0] key,
		input logic [lphs_pkg::HASH_W-1:0] hash,
		output logic [lphs_pkg::STATUS_W-1:0] st,
		output logic [lphs_pkg::SLOT_OUT_W-1:0] sl);
		int unsigned idx;
		int unsigned at;
		bit          hit;
		idx = hash & 32'(SLOTS - 1);
		at  = 0;
		hit = 1'b0;
		sl  = '0;
		if (key != '0) begin
			for (int n = 0; n < SLOTS && !hit; n++) begin
				if (store_keys[idx] == key || store_keys[idx] == '0) begin
					hit = 1'b1;
					at  = idx;
				end else begin
					idx = (idx + 1) & 32'(SLOTS - 1);
				end
			end
		end
		if (cmd == lphs_pkg::CMD_INSERT) begin
			st = lphs_pkg::STAT_FULL;
			if (hit && store_keys[at] == key) begin
				st = lphs_pkg::STAT_PRESENT;
				sl = lphs_pkg::SLOT_OUT_W'(at);
			end else if (hit && store_fill < LOAD_LIMIT) begin
				store_keys[at] = key;
				store_fill++;
				st = lphs_pkg::STAT_NEW;
				sl = lphs_pkg::SLOT_OUT_W'(at);
			end
		end else begin
			st = lphs_pkg::STAT_ABSENT;
			if (hit && store_keys[at] == key) begin
				st = lphs_pkg::STAT_FOUND;
				sl = lphs_pkg::SLOT_OUT_W'(at);
			end
		end
	endfunction

	// entered and left at a falling edge; valid stays high across back-to-back items
	task automatic push_op(input logic cmd, input logic [lphs_pkg::KEY_W-1:0] key,
		input logic [lphs_pkg::HASH_W-1:0] hash, input logic fixed,
		input logic [lphs_pkg::STATUS_W-1:0] fixed_st,
		input logic [lphs_pkg::SLOT_OUT_W-1:0] fixed_sl);
		int       gap;
		outcome_t res;
		gap = calm ? 0 : $urandom_range(7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {hash, key};
		s_tuser  <= cmd;
		do @(posedge clk); while (!s_tready);
		set_outcome(cmd, key, hash, res.st, res.sl);
		if (res.st == lphs_pkg::STAT_NEW) begin
			stored_q.push_back('{key, hash});
			in_set[key] = 1'b1;
		end
		if (fixed) begin
			res.st = fixed_st;
			res.sl = fixed_sl;
		end
		outcome_q.push_back(res);
		@(negedge clk);
	endtask

	initial begin
		int       stall;
		outcome_t want;
		forever begin
			stall = calm ? 0 : $urandom_range(7);
			@(negedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (outcome_q.size() == 0) begin
				$error("result with nothing pending: status=%0d slot=%0d",
					m_tuser, m_tdata[lphs_pkg::SLOT_OUT_W-1:0]);
				mismatches++;
			end else begin
				want = outcome_q.pop_front();
				if (m_tuser !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, m_tuser);
					mismatches++;
				end
				if (m_tdata[lphs_pkg::SLOT_OUT_W-1:0] !== want.sl) begin
					$error("slot: expected %0d, got %0d", want.sl,
						m_tdata[lphs_pkg::SLOT_OUT_W-1:0]);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int                          pick;
		int                          j;
		int                          late_items;
		bit                          at_cap;
		logic                        cmd;
		logic [lphs_pkg::KEY_W-1:0]  key;
		logic [lphs_pkg::HASH_W-1:0] hash;
		late_items = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_ops[i]) begin
			push_op(directed_ops[i].cmd, directed_ops[i].key, directed_ops[i].hash,
				directed_ops[i].fixed, directed_ops[i].st, directed_ops[i].sl);
		end

		// fill up to the cap first, then keep running at the cap for a while
		for (int n = 0; n < 850 || late_items < 60; n++) begin
			if (n % 40 == 0)
				calm = ($urandom_range(3) == 0);
			pick   = $urandom_range(99);
			at_cap = (store_fill >= LOAD_LIMIT);
			if (at_cap)
				late_items++;
			cmd  = lphs_pkg::CMD_INSERT;
			key  = $urandom;
			hash = $urandom;
			if (at_cap ? pick < 30 : pick < 88) begin
				while (key == '0 || in_set.exists(key))
					key = $urandom;
				// crowd home slots around the wrap point and one mid-table run
				j = $urandom_range(9);
				if (j < 4)
					hash[lphs_pkg::SLOT_OUT_W-1:0] =
						lphs_pkg::SLOT_OUT_W'(1016 + $urandom_range(15));
				else if (j < 6)
					hash[lphs_pkg::SLOT_OUT_W-1:0] =
						lphs_pkg::SLOT_OUT_W'(512 + $urandom_range(31));
			end else if (at_cap ? pick < 90 : pick < 96) begin
				j    = $urandom_range(stored_q.size() - 1);
				key  = stored_q[j].key;
				hash = stored_q[j].hash;
				cmd  = (pick % 3 == 0) ? lphs_pkg::CMD_INSERT : lphs_pkg::CMD_LOOKUP;
				if ($urandom_range(15) == 0)
					hash = $urandom;
			end else begin
				cmd = logic'($urandom_range(1));
				if (pick % 2 == 0)
					key = '0;
			end
			push_op(cmd, key, hash, 1'b0, lphs_pkg::STAT_NEW, '0);
		end

		s_tvalid <= 1'b0;
		calm = 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);
		if (mismatches == 0) begin
			$display("** linear_probe_hash_set: PASSED **");
		end else begin
			$display("** linear_probe_hash_set: FAILED **");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/lphs_pkg.sv
rtl/lphs_key_ram.sv
rtl/lphs_probe_unit.sv
rtl/linear_probe_hash_set.sv
dv/tb_linear_probe_hash_set.sv
